FILE: rtl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// Sprite frame sequencer package
// Item types, field widths, command codes, register indexes and reset values
// shared by the sequencer files.
// ----------------------------------------------------------------------------
package sfs_pkg;

   // Field widths
   localparam int SEQ_IDX_W = 4;
   localparam int SEQ_COUNT = 2 ** SEQ_IDX_W;
   localparam int FRAME_W   = 12;
   localparam int TIME_W    = 24;
   localparam int COORD_W   = 24;
   localparam int COLS_W    = 9;
   localparam int PIX_W     = 10;
   localparam int OFS_W     = 13;
   localparam int CMD_W     = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 24;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PLAY   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DEFINE = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_PERIOD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SHEET_COLUMNS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_X_OFFSET      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_Y_OFFSET      = 3'd5;

   // Register reset values
   localparam logic [TIME_W-1:0] RST_FRAME_PERIOD  = 24'd1000;
   localparam logic [COLS_W-1:0] RST_SHEET_COLUMNS = 9'd1;
   localparam logic [PIX_W-1:0]  RST_FRAME_WIDTH   = 10'd16;
   localparam logic [PIX_W-1:0]  RST_FRAME_HEIGHT  = 10'd16;

   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [TIME_W-1:0]    delta_ticks;
      logic [SEQ_IDX_W-1:0] seq_index;
      logic [FRAME_W-1:0]   first_frame;
      logic [FRAME_W-1:0]   last_frame;
   } req_item_type;

   typedef struct packed {
      logic                      playing;
      logic [FRAME_W-1:0]        current_frame;
      logic signed [COORD_W-1:0] source_x;
      logic signed [COORD_W-1:0] source_y;
      logic                      frame_changed;
      logic                      error;
   } rsp_item_type;

endpackage

FILE: rtl/sprite_frame_sequencer.sv
// ----------------------------------------------------------------------------
// Sprite frame sequencer
// Sprite-sheet animation stepper run by a microcoded sequencer: a small
// control store drives a shared restoring divider, the frame and timer
// registers and the coordinate multipliers.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Carries
//  req_      in         valid / stall        one command item
//  rsp_      out        valid / stall        one result item per command
//  csr_      in         valid / ready        register index and write data
//
//  A crossing update runs the shared divider over the ticks, again over the
//  sequence length when the frame wraps rather than steps, and then over the
//  columns, as a play does; define and an idle update never start it, and
//  a non-crossing update does not wait for it. One item at a time.
//  Reset idles the sequencer, clears the valid marks, sets the registers to
//  their reset values and stalls req_. A waiting result holds only the next
//  item's result, not its acceptance.
module sprite_frame_sequencer
   import sfs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_item_type         req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_item_type         rsp_item,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   // Control store layout
   localparam int UPC_W  = 5;
   localparam int OP_W   = 4;
   localparam int COND_W = 4;
   localparam int CNT_W  = 5;
   localparam int PX_W   = COLS_W + PIX_W;
   localparam int PY_W   = FRAME_W + PIX_W;
   localparam int LEN_W  = FRAME_W + 1;

   localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(TIME_W);
   localparam logic [CNT_W-1:0] COL_STEPS = CNT_W'(FRAME_W);

   // Datapath operations
   localparam logic [OP_W-1:0] OP_NOP         = 4'd0;
   localparam logic [OP_W-1:0] OP_EMIT        = 4'd1;
   localparam logic [OP_W-1:0] OP_DIV_TIME    = 4'd2;
   localparam logic [OP_W-1:0] OP_TIME_SUB    = 4'd3;
   localparam logic [OP_W-1:0] OP_TIME_RELOAD = 4'd4;
   localparam logic [OP_W-1:0] OP_DIV_WRAP    = 4'd5;
   localparam logic [OP_W-1:0] OP_FRAME_WRAP  = 4'd6;
   localparam logic [OP_W-1:0] OP_FRAME_STEP  = 4'd7;
   localparam logic [OP_W-1:0] OP_PLAY_LOAD   = 4'd8;
   localparam logic [OP_W-1:0] OP_DEFINE      = 4'd9;
   localparam logic [OP_W-1:0] OP_COORD_START = 4'd10;
   localparam logic [OP_W-1:0] OP_MUL         = 4'd11;
   localparam logic [OP_W-1:0] OP_COORD       = 4'd12;

   // Jump conditions: jump to target when true, else advance
   localparam logic [COND_W-1:0] C_NEVER     = 4'd0;
   localparam logic [COND_W-1:0] C_ALWAYS    = 4'd1;
   localparam logic [COND_W-1:0] C_SLOT_BUSY = 4'd2;
   localparam logic [COND_W-1:0] C_NO_REQ    = 4'd3;
   localparam logic [COND_W-1:0] C_CMD_PLAY  = 4'd4;
   localparam logic [COND_W-1:0] C_CMD_DEF   = 4'd5;
   localparam logic [COND_W-1:0] C_NO_UPDATE = 4'd6;
   localparam logic [COND_W-1:0] C_NO_CROSS  = 4'd7;
   localparam logic [COND_W-1:0] C_DIV_BUSY  = 4'd8;
   localparam logic [COND_W-1:0] C_STEP      = 4'd9;
   localparam logic [COND_W-1:0] C_PLAY_SKIP = 4'd10;

   // Program addresses
   localparam logic [UPC_W-1:0] S_FINISH    = 5'd0;
   localparam logic [UPC_W-1:0] S_IDLE      = 5'd1;
   localparam logic [UPC_W-1:0] S_DISPATCH  = 5'd2;
   localparam logic [UPC_W-1:0] S_DISP_DEF  = 5'd3;
   localparam logic [UPC_W-1:0] S_DISP_UPD  = 5'd4;
   localparam logic [UPC_W-1:0] S_UPD_START = 5'd5;
   localparam logic [UPC_W-1:0] S_UPD_WAIT  = 5'd6;
   localparam logic [UPC_W-1:0] S_UPD_LOAD  = 5'd7;
   localparam logic [UPC_W-1:0] S_WRAP_DIV  = 5'd8;
   localparam logic [UPC_W-1:0] S_WRAP_WAIT = 5'd9;
   localparam logic [UPC_W-1:0] S_WRAP_SET  = 5'd10;
   localparam logic [UPC_W-1:0] S_STEP_SET  = 5'd11;
   localparam logic [UPC_W-1:0] S_NO_CROSS  = 5'd12;
   localparam logic [UPC_W-1:0] S_PLAY_CHK  = 5'd13;
   localparam logic [UPC_W-1:0] S_PLAY_LOAD = 5'd14;
   localparam logic [UPC_W-1:0] S_COORD     = 5'd15;
   localparam logic [UPC_W-1:0] S_COORD_WT  = 5'd16;
   localparam logic [UPC_W-1:0] S_COORD_MUL = 5'd17;
   localparam logic [UPC_W-1:0] S_COORD_SUM = 5'd18;
   localparam logic [UPC_W-1:0] S_DEFINE    = 5'd19;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic [UPC_W-1:0]  target;
   } ctrl_word_type;

   // Control store
   function automatic ctrl_word_type ucode(input logic [UPC_W-1:0] addr);
      ctrl_word_type w;
      begin
         case (addr)
            S_FINISH:    w = '{OP_EMIT,        C_SLOT_BUSY, S_FINISH};
            S_IDLE:      w = '{OP_NOP,         C_NO_REQ,    S_IDLE};
            S_DISPATCH:  w = '{OP_NOP,         C_CMD_PLAY,  S_PLAY_CHK};
            S_DISP_DEF:  w = '{OP_NOP,         C_CMD_DEF,   S_DEFINE};
            S_DISP_UPD:  w = '{OP_NOP,         C_NO_UPDATE, S_FINISH};
            S_UPD_START: w = '{OP_DIV_TIME,    C_NO_CROSS,  S_NO_CROSS};
            S_UPD_WAIT:  w = '{OP_NOP,         C_DIV_BUSY,  S_UPD_WAIT};
            S_UPD_LOAD:  w = '{OP_TIME_RELOAD, C_STEP,      S_STEP_SET};
            S_WRAP_DIV:  w = '{OP_DIV_WRAP,    C_NEVER,     S_FINISH};
            S_WRAP_WAIT: w = '{OP_NOP,         C_DIV_BUSY,  S_WRAP_WAIT};
            S_WRAP_SET:  w = '{OP_FRAME_WRAP,  C_ALWAYS,    S_COORD};
            S_STEP_SET:  w = '{OP_FRAME_STEP,  C_ALWAYS,    S_COORD};
            S_NO_CROSS:  w = '{OP_TIME_SUB,    C_ALWAYS,    S_FINISH};
            S_PLAY_CHK:  w = '{OP_NOP,         C_PLAY_SKIP, S_FINISH};
            S_PLAY_LOAD: w = '{OP_PLAY_LOAD,   C_NEVER,     S_FINISH};
            S_COORD:     w = '{OP_COORD_START, C_NEVER,     S_FINISH};
            S_COORD_WT:  w = '{OP_NOP,         C_DIV_BUSY,  S_COORD_WT};
            S_COORD_MUL: w = '{OP_MUL,         C_NEVER,     S_FINISH};
            S_COORD_SUM: w = '{OP_COORD,       C_ALWAYS,    S_FINISH};
            S_DEFINE:    w = '{OP_DEFINE,      C_ALWAYS,    S_FINISH};
            default:     w = '{OP_NOP,         C_ALWAYS,    S_IDLE};
         endcase
         return w;
      end
   endfunction

   // Sequencer
   logic [UPC_W-1:0] upc_ff, upc_in;
   ctrl_word_type    ctrl;
   logic             cond_true;

   // Configuration registers
   logic [TIME_W-1:0] period_ff, period_in;
   logic [COLS_W-1:0] cols_ff, cols_in;
   logic [PIX_W-1:0]  fwidth_ff, fwidth_in;
   logic [PIX_W-1:0]  fheight_ff, fheight_in;
   logic [OFS_W-1:0]  xoff_ff, xoff_in;
   logic [OFS_W-1:0]  yoff_ff, yoff_in;

   // Item and animation state
   req_item_type         item_ff, item_in;
   logic                 playing_ff, playing_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic [SEQ_IDX_W-1:0] active_ff, active_in;
   logic [TIME_W-1:0]    time_left_ff, time_left_in;
   logic [COORD_W-1:0]   src_x_ff, src_x_in;
   logic [COORD_W-1:0]   src_y_ff, src_y_in;
   logic [SEQ_COUNT-1:0] valid_ff, valid_in;
   logic                 changed_ff, changed_in;
   logic                 error_ff, error_in;
   logic [PX_W-1:0]      prod_x_ff, prod_x_in;
   logic [PY_W-1:0]      prod_y_ff, prod_y_in;

   // Divider
   logic [TIME_W-1:0] div_rem_ff, div_rem_in;
   logic [TIME_W-1:0] div_quo_ff, div_quo_in;
   logic [TIME_W-1:0] div_dvs_ff, div_dvs_in;
   logic [CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic              div_busy_ff, div_busy_in;
   logic [TIME_W:0]   div_shift;
   logic [TIME_W:0]   div_diff;
   logic              div_fit;

   // Output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   // Sequence store
   logic                   seq_wr_en;
   logic [SEQ_IDX_W-1:0]   seq_rd_addr;
   logic [2*FRAME_W-1:0]   seq_rd_data;
   logic [FRAME_W-1:0]     seq_first;
   logic [FRAME_W-1:0]     seq_last;

   // Derived values
   logic              req_accept;
   logic              slot_busy;
   logic [TIME_W-1:0] period_eff;
   logic [COLS_W-1:0] cols_eff;
   logic [FRAME_W-1:0] to_last;
   logic [LEN_W-1:0]  seq_len;
   logic              crossing;
   logic              bad_define;

   assign ctrl       = ucode(upc_ff);
   assign req_stall  = reset || (upc_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign slot_busy  = rsp_valid_ff && rsp_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;

   assign period_eff = (period_ff == '0) ? TIME_W'(1) : period_ff;
   assign cols_eff   = (cols_ff == '0) ? COLS_W'(1) : cols_ff;
   assign seq_first  = seq_rd_data[2*FRAME_W-1:FRAME_W];
   assign seq_last   = seq_rd_data[FRAME_W-1:0];
   assign to_last    = seq_last - frame_ff;
   assign seq_len    = LEN_W'(seq_last) - LEN_W'(seq_first) + LEN_W'(1);
   assign crossing   = item_ff.delta_ticks > time_left_ff;
   assign bad_define = item_ff.first_frame > item_ff.last_frame;

   // Read the entry being played, or the play target while a play runs
   assign seq_rd_addr = (item_ff.cmd == CMD_PLAY) ? item_ff.seq_index : active_ff;
   assign seq_wr_en   = (ctrl.op == OP_DEFINE) && !bad_define;

   sfs_ram #(
      .WIDTH (2 * FRAME_W),
      .DEPTH (SEQ_COUNT)
   ) u_seq_ram (
      .clock   (clock),
      .wr_en   (seq_wr_en),
      .wr_addr (item_ff.seq_index),
      .wr_data ({item_ff.first_frame, item_ff.last_frame}),
      .rd_addr (seq_rd_addr),
      .rd_data (seq_rd_data)
   );

   // Evaluate the jump condition and pick the next step
   always_comb begin
      case (ctrl.cond)
         C_NEVER:     cond_true = 1'b0;
         C_ALWAYS:    cond_true = 1'b1;
         C_SLOT_BUSY: cond_true = slot_busy;
         C_NO_REQ:    cond_true = !req_accept;
         C_CMD_PLAY:  cond_true = (item_ff.cmd == CMD_PLAY);
         C_CMD_DEF:   cond_true = (item_ff.cmd == CMD_DEFINE);
         C_NO_UPDATE: cond_true = (item_ff.cmd != CMD_UPDATE) || !playing_ff ||
                                  !valid_ff[active_ff];
         C_NO_CROSS:  cond_true = !crossing;
         C_DIV_BUSY:  cond_true = div_busy_ff;
         C_STEP:      cond_true = div_quo_ff < TIME_W'(to_last);
         C_PLAY_SKIP: cond_true = !valid_ff[item_ff.seq_index] ||
                                  (playing_ff && (active_ff == item_ff.seq_index));
         default:     cond_true = 1'b0;
      endcase
      upc_in = cond_true ? ctrl.target : upc_ff + UPC_W'(1);
   end

   // Take register writes
   always_comb begin
      period_in  = period_ff;
      cols_in    = cols_ff;
      fwidth_in  = fwidth_ff;
      fheight_in = fheight_ff;
      xoff_in    = xoff_ff;
      yoff_in    = yoff_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_FRAME_PERIOD:  period_in  = csr_wdata[TIME_W-1:0];
            REG_SHEET_COLUMNS: cols_in    = csr_wdata[COLS_W-1:0];
            REG_FRAME_WIDTH:   fwidth_in  = csr_wdata[PIX_W-1:0];
            REG_FRAME_HEIGHT:  fheight_in = csr_wdata[PIX_W-1:0];
            REG_X_OFFSET:      xoff_in    = csr_wdata[OFS_W-1:0];
            REG_Y_OFFSET:      yoff_in    = csr_wdata[OFS_W-1:0];
            default: ;
         endcase
      end
   end

   // Divider: one quotient bit a cycle, restarted by the start operations
   assign div_shift = {div_rem_ff, div_quo_ff[TIME_W-1]};
   assign div_diff  = div_shift - {1'b0, div_dvs_ff};
   assign div_fit   = !div_diff[TIME_W];

   always_comb begin
      div_rem_in  = div_rem_ff;
      div_quo_in  = div_quo_ff;
      div_dvs_in  = div_dvs_ff;
      div_cnt_in  = div_cnt_ff;
      div_busy_in = div_busy_ff;
      if (div_busy_ff) begin
         div_rem_in  = div_fit ? div_diff[TIME_W-1:0] : div_shift[TIME_W-1:0];
         div_quo_in  = {div_quo_ff[TIME_W-2:0], div_fit};
         div_cnt_in  = div_cnt_ff - CNT_W'(1);
         div_busy_in = (div_cnt_ff != CNT_W'(1));
      end
      case (ctrl.op)
         OP_DIV_TIME: begin
            // ticks beyond the current frame, less one, over the period
            div_quo_in  = item_ff.delta_ticks - time_left_ff - TIME_W'(1);
            div_dvs_in  = period_eff;
            div_cnt_in  = DIV_STEPS;
            div_rem_in  = '0;
            div_busy_in = 1'b1;
         end
         OP_DIV_WRAP: begin
            // frames past the last one, less one, modulo the sequence length
            div_quo_in  = div_quo_ff - TIME_W'(to_last);
            div_dvs_in  = TIME_W'(seq_len);
            div_cnt_in  = DIV_STEPS;
            div_rem_in  = '0;
            div_busy_in = 1'b1;
         end
         OP_COORD_START: begin
            // frame over columns; the frame sits in the top bits
            div_quo_in  = {frame_ff, {(TIME_W-FRAME_W){1'b0}}};
            div_dvs_in  = TIME_W'(cols_eff);
            div_cnt_in  = COL_STEPS;
            div_rem_in  = '0;
            div_busy_in = 1'b1;
         end
         default: ;
      endcase
   end

   // Animation datapath
   always_comb begin
      item_in      = item_ff;
      playing_in   = playing_ff;
      frame_in     = frame_ff;
      active_in    = active_ff;
      time_left_in = time_left_ff;
      src_x_in     = src_x_ff;
      src_y_in     = src_y_ff;
      valid_in     = valid_ff;
      changed_in   = changed_ff;
      error_in     = error_ff;
      prod_x_in    = prod_x_ff;
      prod_y_in    = prod_y_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;

      if (req_accept) begin
         item_in    = req_item;
         changed_in = 1'b0;
         error_in   = 1'b0;
      end

      case (ctrl.op)
         OP_EMIT: begin
            if (!slot_busy) begin
               rsp_valid_in                = 1'b1;
               rsp_item_in.playing         = playing_ff;
               rsp_item_in.current_frame   = playing_ff ? frame_ff : '0;
               rsp_item_in.source_x        = src_x_ff;
               rsp_item_in.source_y        = src_y_ff;
               rsp_item_in.frame_changed   = changed_ff;
               rsp_item_in.error           = error_ff;
            end
         end
         OP_TIME_SUB: begin
            time_left_in = time_left_ff - item_ff.delta_ticks;
         end
         OP_TIME_RELOAD: begin
            time_left_in = period_eff - div_rem_ff - TIME_W'(1);
         end
         OP_FRAME_WRAP: begin
            frame_in = seq_first + div_rem_ff[FRAME_W-1:0];
         end
         OP_FRAME_STEP: begin
            frame_in = frame_ff + div_quo_ff[FRAME_W-1:0] + FRAME_W'(1);
         end
         OP_PLAY_LOAD: begin
            frame_in     = seq_first;
            active_in    = item_ff.seq_index;
            playing_in   = 1'b1;
            time_left_in = period_eff;
         end
         OP_DEFINE: begin
            if (bad_define) begin
               error_in = 1'b1;
            end else begin
               valid_in[item_ff.seq_index] = 1'b1;
            end
         end
         OP_COORD_START: begin
            changed_in = 1'b1;
         end
         OP_MUL: begin
            prod_x_in = div_rem_ff[COLS_W-1:0] * fwidth_ff;
            prod_y_in = div_quo_ff[FRAME_W-1:0] * fheight_ff;
         end
         OP_COORD: begin
            src_x_in = COORD_W'(prod_x_ff) + {{(COORD_W-OFS_W){xoff_ff[OFS_W-1]}}, xoff_ff};
            src_y_in = COORD_W'(prod_y_ff) + {{(COORD_W-OFS_W){yoff_ff[OFS_W-1]}}, yoff_ff};
         end
         default: ;
      endcase
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= S_IDLE;
         period_ff    <= RST_FRAME_PERIOD;
         cols_ff      <= RST_SHEET_COLUMNS;
         fwidth_ff    <= RST_FRAME_WIDTH;
         fheight_ff   <= RST_FRAME_HEIGHT;
         xoff_ff      <= '0;
         yoff_ff      <= '0;
         playing_ff   <= 1'b0;
         frame_ff     <= '0;
         active_ff    <= '0;
         time_left_ff <= RST_FRAME_PERIOD;
         src_x_ff     <= '0;
         src_y_ff     <= '0;
         valid_ff     <= '0;
         changed_ff   <= 1'b0;
         error_ff     <= 1'b0;
         div_cnt_ff   <= '0;
         div_busy_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         period_ff    <= period_in;
         cols_ff      <= cols_in;
         fwidth_ff    <= fwidth_in;
         fheight_ff   <= fheight_in;
         xoff_ff      <= xoff_in;
         yoff_ff      <= yoff_in;
         playing_ff   <= playing_in;
         frame_ff     <= frame_in;
         active_ff    <= active_in;
         time_left_ff <= time_left_in;
         src_x_ff     <= src_x_in;
         src_y_ff     <= src_y_in;
         valid_ff     <= valid_in;
         changed_ff   <= changed_in;
         error_ff     <= error_in;
         div_cnt_ff   <= div_cnt_in;
         div_busy_ff  <= div_busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_dvs_ff  <= div_dvs_in;
      prod_x_ff   <= prod_x_in;
      prod_y_ff   <= prod_y_in;
      rsp_item_ff <= rsp_item_in;
   end

   // A wrapped frame lands inside its sequence
   a_wrap_in_seq: assert property (@(posedge clock) disable iff (reset)
      $past(ctrl.op == OP_FRAME_WRAP) |-> (frame_ff >= seq_first) && (frame_ff <= seq_last))
      else $error("wrapped frame outside its sequence");

   // A reloaded timer stays below the period
   a_reload_range: assert property (@(posedge clock) disable iff (reset)
      $past(ctrl.op == OP_TIME_RELOAD) |-> time_left_ff < period_eff)
      else $error("frame timer reloaded at or above the period");

   // The divider finishes with a remainder below its divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      $fell(div_busy_ff) |-> div_rem_ff < div_dvs_ff)
      else $error("divider remainder not below divisor");

   // Play, once started, never stops
   a_playing_holds: assert property (@(posedge clock) disable iff (reset)
      playing_ff |=> playing_ff)
      else $error("playing flag dropped");

endmodule

FILE: rtl/sfs_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sprite frame sequencer testbench
// Sends command items through the sequencer under several register settings
// and idling patterns, and checks every result item, field by field, against
// a bench model of the animation stepper kept in step with accepted items.
// ----------------------------------------------------------------------------
module tb;
   import sfs_pkg::*;

   // Cycles with no accepted item, result or register write before the run is
   // abandoned; it must cover the slowest item plus a long receiver stall
   localparam int QUIET_LIMIT  = 5000;
   // Hold-off after the last result, a little over the slowest item
   localparam int DRAIN_CYCLES = 100;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 80;

   // Command code and register index with no function in the sequencer
   localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd6;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_item_type         req_item  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_item_type         rsp_item;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // Item traffic
   req_item_type cmd_backlog[$];
   rsp_item_type frames_due[$];
   int unsigned  queued_count   = 0;
   int unsigned  taken_count    = 0;
   logic         req_taken      = 1'b0;
   int unsigned  send_idle_pct  = 0;
   int unsigned  recv_stall_pct = 0;
   int unsigned  quiet_cycles   = 0;
   int unsigned  fault_count    = 0;

   // Register copies, at their reset values
   logic [TIME_W-1:0] cfg_period  = RST_FRAME_PERIOD;
   logic [COLS_W-1:0] cfg_columns = RST_SHEET_COLUMNS;
   logic [PIX_W-1:0]  cfg_width   = RST_FRAME_WIDTH;
   logic [PIX_W-1:0]  cfg_height  = RST_FRAME_HEIGHT;
   logic [OFS_W-1:0]  cfg_xoff    = '0;
   logic [OFS_W-1:0]  cfg_yoff    = '0;

   // Animation state, at its reset values
   bit                   anim_on    = 1'b0;
   logic [FRAME_W-1:0]   anim_frame = '0;
   logic [SEQ_IDX_W-1:0] anim_seq   = '0;
   logic [TIME_W-1:0]    ticks_left = RST_FRAME_PERIOD;
   logic [COORD_W-1:0]   sheet_x    = '0;
   logic [COORD_W-1:0]   sheet_y    = '0;
   bit [FRAME_W-1:0]     slot_first[SEQ_COUNT];
   bit [FRAME_W-1:0]     slot_last[SEQ_COUNT];
   bit                   slot_valid[SEQ_COUNT];

   sprite_frame_sequencer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // Sheet coordinates of the frame now shown
   function automatic void place_frame();
      longint cols, fx, fy;
      cols = (cfg_columns == 0) ? 1 : longint'(cfg_columns);
      fx = longint'(anim_frame) % cols;
      fy = longint'(anim_frame) / cols;
      sheet_x = COORD_W'(fx * longint'(cfg_width) + longint'($signed(cfg_xoff)));
      sheet_y = COORD_W'(fy * longint'(cfg_height) + longint'($signed(cfg_yoff)));
   endfunction

   // Apply one command to the animation state and return its result item
   function automatic rsp_item_type step_animation(req_item_type it);
      rsp_item_type    res;
      longint unsigned per, d1, steps, rem, to_last, span;
      bit              changed, bad;
      changed = 1'b0;
      bad     = 1'b0;
      per     = (cfg_period == 0) ? 1 : longint'(cfg_period);
      case (it.cmd)
         CMD_UPDATE: begin
            if (anim_on && slot_valid[anim_seq]) begin
               if (it.delta_ticks > ticks_left) begin
                  d1 = it.delta_ticks - ticks_left;
                  steps = 1 + ((d1 != 0) ? (d1 - 1) / per : 0);
                  rem = d1 - (steps - 1) * per;
                  ticks_left = TIME_W'(per - rem);
                  // count up to last, then wrap round the sequence
                  to_last = (64'(slot_last[anim_seq]) - 64'(anim_frame)) & 64'hFFF;
                  if (steps <= to_last) begin
                     anim_frame = FRAME_W'(64'(anim_frame) + steps);
                  end else begin
                     span = 64'(slot_last[anim_seq]) - 64'(slot_first[anim_seq]) + 1;
                     anim_frame = FRAME_W'(64'(slot_first[anim_seq]) +
                                           (steps - to_last - 1) % span);
                  end
                  place_frame();
                  changed = 1'b1;
               end else begin
                  ticks_left = ticks_left - it.delta_ticks;
               end
            end
         end
         CMD_PLAY: begin
            if (slot_valid[it.seq_index] && !(anim_on && anim_seq == it.seq_index)) begin
               anim_frame = slot_first[it.seq_index];
               anim_seq   = it.seq_index;
               anim_on    = 1'b1;
               ticks_left = TIME_W'(per);
               place_frame();
               changed = 1'b1;
            end
         end
         CMD_DEFINE: begin
            if (it.first_frame > it.last_frame) begin
               bad = 1'b1;
            end else begin
               slot_first[it.seq_index] = it.first_frame;
               slot_last[it.seq_index]  = it.last_frame;
               slot_valid[it.seq_index] = 1'b1;
            end
         end
         default: ;
      endcase
      res.playing       = anim_on;
      res.current_frame = anim_on ? anim_frame : '0;
      res.source_x      = sheet_x;
      res.source_y      = sheet_y;
      res.frame_changed = changed;
      res.error         = bad;
      return res;
   endfunction

   task automatic check_field(string field, logic [COORD_W-1:0] want,
                              logic [COORD_W-1:0] got);
      if (want !== got) begin
         $error("tb: %s expected %0h, got %0h", field, want, got);
         fault_count++;
      end
   endtask

   // Queue one command item for the driver
   task automatic push_cmd(logic [CMD_W-1:0] cmd, int unsigned delta, int unsigned idx,
                           int unsigned ff, int unsigned lf);
      req_item_type it;
      it.cmd         = cmd;
      it.delta_ticks = TIME_W'(delta);
      it.seq_index   = SEQ_IDX_W'(idx);
      it.first_frame = FRAME_W'(ff);
      it.last_frame  = FRAME_W'(lf);
      cmd_backlog.push_back(it);
      queued_count++;
   endtask

   // Write one register and mirror it once accepted
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_FRAME_PERIOD:  cfg_period  = data[TIME_W-1:0];
         REG_SHEET_COLUMNS: cfg_columns = data[COLS_W-1:0];
         REG_FRAME_WIDTH:   cfg_width   = data[PIX_W-1:0];
         REG_FRAME_HEIGHT:  cfg_height  = data[PIX_W-1:0];
         REG_X_OFFSET:      cfg_xoff    = data[OFS_W-1:0];
         REG_Y_OFFSET:      cfg_yoff    = data[OFS_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Hold until every queued item has been taken and answered
   task automatic drain();
      while (taken_count != queued_count || frames_due.size() != 0)
         @(posedge clock);
   endtask

   // Driver: present the next item or idle, and stall the result channel
   always @(negedge clock) begin
      if (!req_valid || req_taken) begin
         if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_item  <= cmd_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Monitor: check result items, predict from accepted command items
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (frames_due.size() == 0) begin
               $error("tb: result item with no expectation waiting");
               fault_count++;
            end else begin : compare
               rsp_item_type want;
               want = frames_due.pop_front();
               check_field("playing", want.playing, rsp_item.playing);
               check_field("current_frame", want.current_frame, rsp_item.current_frame);
               check_field("source_x", want.source_x, rsp_item.source_x);
               check_field("source_y", want.source_y, rsp_item.source_y);
               check_field("frame_changed", want.frame_changed, rsp_item.frame_changed);
               check_field("error", want.error, rsp_item.error);
            end
         end
         if (req_valid && !req_stall) begin
            frames_due.push_back(step_animation(req_item));
            taken_count++;
         end
      end
      req_taken <= !reset && req_valid && !req_stall;
   end

   // Watchdog: abandon the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus
   initial begin
      int unsigned pick, slot, ff, lf, per, reach, delta;
      bit          planned[SEQ_COUNT];

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset register values
      push_cmd(CMD_UPDATE, 24'hFFFFFF, 0, 0, 0);       // update while idle
      push_cmd(CMD_PLAY, 0, 3, 0, 0);                  // never defined
      push_cmd(CMD_DEFINE, 0, 0, 5, 9);
      push_cmd(CMD_DEFINE, 0, 1, 10, 3);               // first above last
      push_cmd(CMD_DEFINE, 0, 15, 0, 4095);
      push_cmd(CMD_DEFINE, 0, 2, 4095, 4095);
      push_cmd(CMD_PLAY, 0, 0, 0, 0);
      push_cmd(CMD_PLAY, 0, 0, 0, 0);                  // already playing
      push_cmd(CMD_UPDATE, 0, 0, 0, 0);
      push_cmd(CMD_UPDATE, 999, 0, 0, 0);              // no crossing
      push_cmd(CMD_UPDATE, 1, 0, 0, 0);                // timer down to zero
      push_cmd(CMD_UPDATE, 1, 0, 0, 0);                // one step
      push_cmd(CMD_UPDATE, 3500, 0, 0, 0);             // steps to the last frame
      push_cmd(CMD_UPDATE, 24'hFFFFFF, 0, 0, 0);
      push_cmd(CMD_DEFINE, 0, 0, 100, 200);            // redefine while playing
      push_cmd(CMD_UPDATE, 5000, 0, 0, 0);             // frame below new first
      push_cmd(CMD_PLAY, 0, 15, 0, 0);
      push_cmd(CMD_UPDATE, 24'hFFFFFF, 15, 4095, 4095);
      push_cmd(CMD_PLAY, 0, 2, 0, 0);
      push_cmd(CMD_UPDATE, 3000, 0, 0, 0);             // one-frame sequence
      push_cmd(CMD_UNUSED, 24'hFFFFFF, 15, 4095, 4095);
      push_cmd(CMD_DEFINE, 24'hFFFFFF, 15, 4095, 0);   // rejected, slot kept
      push_cmd(CMD_DEFINE, 24'hFFFFFF, 14, 4095, 4095);
      push_cmd(CMD_PLAY, 0, 14, 0, 0);
      push_cmd(CMD_UPDATE, 1001, 0, 0, 0);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         // Register settings: both extremes, the zero cases, then random
         case (ph)
            0: begin
               write_reg(REG_FRAME_PERIOD, 24'hFFFFFF);
               write_reg(REG_SHEET_COLUMNS, 24'd256);
               write_reg(REG_FRAME_WIDTH, 24'd1023);
               write_reg(REG_FRAME_HEIGHT, 24'd1023);
               write_reg(REG_X_OFFSET, 24'h000FFF);
               write_reg(REG_Y_OFFSET, 24'h000FFF);
               write_reg(REG_UNUSED, CSR_DAT_W'($urandom));
            end
            1: begin
               write_reg(REG_FRAME_PERIOD, 24'd1);
               write_reg(REG_SHEET_COLUMNS, 24'd1);
               write_reg(REG_FRAME_WIDTH, 24'd1);
               write_reg(REG_FRAME_HEIGHT, 24'd1);
               write_reg(REG_X_OFFSET, 24'h001000);
               write_reg(REG_Y_OFFSET, 24'h001000);
            end
            2: begin
               write_reg(REG_FRAME_PERIOD, 24'd0);
               write_reg(REG_SHEET_COLUMNS, 24'd0);
               write_reg(REG_FRAME_WIDTH, CSR_DAT_W'($urandom_range(1, 1023)));
               write_reg(REG_FRAME_HEIGHT, CSR_DAT_W'($urandom_range(1, 1023)));
               write_reg(REG_X_OFFSET, CSR_DAT_W'($urandom));
               write_reg(REG_Y_OFFSET, CSR_DAT_W'($urandom));
            end
            default: begin
               write_reg(REG_FRAME_PERIOD, CSR_DAT_W'(($urandom_range(0, 3) == 0) ?
                         $urandom_range(1, 5000) : $urandom_range(1, 40)));
               write_reg(REG_SHEET_COLUMNS, CSR_DAT_W'(($urandom_range(0, 3) == 0) ?
                         256 : $urandom_range(1, 16)));
               write_reg(REG_FRAME_WIDTH, CSR_DAT_W'($urandom_range(1, 1023)));
               write_reg(REG_FRAME_HEIGHT, CSR_DAT_W'($urandom_range(1, 1023)));
               write_reg(REG_X_OFFSET, CSR_DAT_W'($urandom));
               write_reg(REG_Y_OFFSET, CSR_DAT_W'($urandom));
            end
         endcase

         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase

         // Track which slots will hold a sequence, to aim most plays at them
         for (int s = 0; s < SEQ_COUNT; s++) planned[s] = slot_valid[s];
         per   = (cfg_period == 0) ? 1 : cfg_period;
         reach = (3 * per > 24'hFFFFFF) ? 24'hFFFFFF : 3 * per;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            slot = $urandom_range(0, SEQ_COUNT - 1);
            if (pick < 45) begin
               // update, mostly near the frame period
               case ($urandom_range(0, 3))
                  0, 1: delta = $urandom_range(0, reach);
                  2: delta = $urandom_range(0, 24'hFFFFFF);
                  default: delta = $urandom_range(0, 8);
               endcase
               push_cmd(CMD_UPDATE, delta, $urandom, $urandom, $urandom);
            end else if (pick < 65) begin
               repeat (8) if (!planned[slot]) slot = $urandom_range(0, SEQ_COUNT - 1);
               push_cmd(CMD_PLAY, $urandom, slot, $urandom, $urandom);
            end else if (pick < 85) begin
               // well-formed define, short sequences mostly
               ff = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) :
                                                  $urandom_range(0, 40);
               lf = ff + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) :
                                                        $urandom_range(0, 6));
               if (lf > 4095) lf = 4095;
               planned[slot] = 1'b1;
               push_cmd(CMD_DEFINE, $urandom, slot, ff, lf);
            end else if (pick < 92) begin
               ff = $urandom_range(1, 4095);
               lf = $urandom_range(0, ff - 1);
               push_cmd(CMD_DEFINE, $urandom, slot, ff, lf);
            end else if (pick < 96) begin
               push_cmd(CMD_PLAY, $urandom, slot, $urandom, $urandom);
            end else begin
               push_cmd(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
            end
         end
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
